// ===== design/chr_pkg.sv =====
// chr_pkg: shared codes, constants and helpers for the chunky ham to rgb decoder
// used by chunky_ham_to_rgb, chr_checker and the testbench; no dependencies
package chr_pkg;

  // default for the top level parameter
  localparam int DEF_MAX_ROW_PIXELS = 4096;

  // fixed widths of the word fields
  localparam int KIND_W  = 2;
  localparam int PIXEL_W = 8;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 32;
  localparam int IN_W    = PIXEL_W + INDEX_W + COLOR_W;
  localparam int TAB_D   = 1 << INDEX_W;

  // configuration register widths
  localparam int MODE_W  = 2;
  localparam int LEFT_W  = 12;
  localparam int RWID_W  = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  // word kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEN     = 2'd2;

  // color modes, anything else decodes as palette lookup
  localparam logic [MODE_W-1:0] MODE_CLUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HAM6 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HAM8 = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_COLOR_MODE    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_USE_PEN_TABLE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEFT_EDGE     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_ROW_WIDTH     = 2'd3;

  // hold-and-modify masks
  localparam logic [COLOR_W-1:0] WIDEN_MASK  = 32'h00f0f0f0;
  localparam logic [COLOR_W-1:0] KEEP_RG     = 32'h00ffff00;
  localparam logic [COLOR_W-1:0] KEEP_GB     = 32'h0000ffff;
  localparam logic [COLOR_W-1:0] KEEP_RB     = 32'h00ff00ff;
  localparam logic [COLOR_W-1:0] KEEP_RG8    = 32'h00ffff03;
  localparam logic [COLOR_W-1:0] KEEP_GB8    = 32'h0003ffff;
  localparam logic [COLOR_W-1:0] KEEP_RB8    = 32'h00ff03ff;

  // copy the high nibble of each component into its low nibble
  function automatic logic [COLOR_W-1:0] widen4(input logic [COLOR_W-1:0] v);
    logic [COLOR_W-1:0] c;
    c = v & WIDEN_MASK;
    return c | (c >> 4);
  endfunction

endpackage

// ===== design/chunky_ham_to_rgb.sv =====
// chunky_ham_to_rgb: 8-bit chunky pixels to 32-bit rgb words, clut / ham6 / ham8
// depends on chr_pkg and chr_ram (pen table and two palette copies)
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+-------------------------------
//  s        | s_tvalid s_tready s_tdata s_tuser    | pixel and table write words
//  m        | m_tvalid m_tready m_tdata m_tlast    | rgb words, tlast ends a row
//  cfg      | cfg_we cfg_index cfg_data            | mode, pen enable, left edge, width
//
// one word per cycle sustained while m does not stall; a pixel taken on s passes in order through:
// pen table read, then palette read, then the held colour update into the output register
// rst clears the pipeline, the held colour, the column and the registers; the tables
// are not cleared and read as garbage until written
// a stall on m freezes every stage: s_tready = !m_tvalid || m_tready
module chunky_ham_to_rgb
  import chr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
) (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // pixel[7:0], table_index[15:8], table_value[47:16]
  input  logic [KIND_W-1:0]   s_tuser,   // kind[1:0]
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [COLOR_W-1:0]  m_tdata,   // rgb[31:0]
  output logic                m_tlast,   // row_last
  // configuration
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // column reaches at most left_edge + row width - 1
  localparam int COL_W = $clog2((1 << LEFT_W) + MAX_ROW_PIXELS);

  // configuration registers
  logic [MODE_W-1:0] color_mode;
  logic              use_pen_table;
  logic [LEFT_W-1:0] left_edge;
  logic [RWID_W-1:0] row_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode    <= MODE_CLUT;
      use_pen_table <= 1'b0;
      left_edge     <= '0;
      row_width     <= RWID_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_MODE:    color_mode    <= cfg_data[MODE_W-1:0];
        REG_USE_PEN_TABLE: use_pen_table <= cfg_data[0];
        REG_LEFT_EDGE:     left_edge     <= cfg_data[LEFT_W-1:0];
        REG_ROW_WIDTH:     row_width     <= cfg_data[RWID_W-1:0];
      endcase
    end
  end

  logic ham6, ham8;
  assign ham6 = (color_mode == MODE_HAM6);
  assign ham8 = (color_mode == MODE_HAM8);

  // input word fields
  logic [PIXEL_W-1:0] in_pixel;
  logic [INDEX_W-1:0] in_index;
  logic [COLOR_W-1:0] in_value;
  assign in_pixel = s_tdata[PIXEL_W-1:0];
  assign in_index = s_tdata[PIXEL_W +: INDEX_W];
  assign in_value = s_tdata[PIXEL_W+INDEX_W +: COLOR_W];

  // whole pipeline moves together, the output register parts the two sides
  logic en, accept, pen_we, pal_we;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  // table writes land at accept, so later pixels see them and earlier ones do not
  assign pen_we   = accept && (s_tuser == KIND_PEN);
  assign pal_we   = accept && (s_tuser == KIND_PALETTE);

  // copy of pen entry zero for the row start colour
  logic [PIXEL_W-1:0] pen0;
  always_ff @(posedge clk) begin
    if (pen_we && in_index == '0) begin
      pen0 <= in_value[PIXEL_W-1:0];
    end
  end

  // stage 1: pen table read
  logic [PIXEL_W-1:0] pen_rdata;
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;

  chr_ram #(.WIDTH(PIXEL_W), .DEPTH(TAB_D)) u_pen (
    .clk   (clk),
    .we    (pen_we),
    .waddr (in_index),
    .wdata (in_value[PIXEL_W-1:0]),
    .re    (en),
    .raddr (in_pixel),
    .rdata (pen_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && (s_tuser == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pixel <= in_pixel;
    end
  end

  // stage 2: palette reads, one copy for the pixel and one for the row start
  logic [PIXEL_W-1:0] p1, pal_a_addr, pal_b_addr;
  logic [COLOR_W-1:0] pal_a_rdata, pal_b_rdata;
  logic               s2_valid;
  logic [PIXEL_W-1:0] s2_p;

  assign p1 = use_pen_table ? pen_rdata : s1_pixel;

  always_comb begin
    if (ham6) begin
      pal_a_addr = {4'b0, p1[3:0]};
    end else if (ham8) begin
      pal_a_addr = {2'b0, p1[5:0]};
    end else begin
      pal_a_addr = p1;
    end
  end

  assign pal_b_addr = use_pen_table ? pen0 : '0;

  chr_ram #(.WIDTH(COLOR_W), .DEPTH(TAB_D)) u_pal_a (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_index),
    .wdata (in_value),
    .re    (en),
    .raddr (pal_a_addr),
    .rdata (pal_a_rdata)
  );

  chr_ram #(.WIDTH(COLOR_W), .DEPTH(TAB_D)) u_pal_b (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_index),
    .wdata (in_value),
    .re    (en),
    .raddr (pal_b_addr),
    .rdata (pal_b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p <= p1;
    end
  end

  // stage 3: held colour update and column count
  logic [COLOR_W-1:0] held_color, held_color_next, base, rgb;
  logic [COL_W-1:0]   column, column_next, width, last_col;
  logic               emit, is_last;

  always_comb begin
    // zero width counts as one, oversize saturates
    if (row_width == '0) begin
      width = COL_W'(1);
    end else if (COL_W'(row_width) > COL_W'(MAX_ROW_PIXELS)) begin
      width = COL_W'(MAX_ROW_PIXELS);
    end else begin
      width = COL_W'(row_width);
    end
    last_col = COL_W'(left_edge) + width - COL_W'(1);
  end

  always_comb begin
    // row start reloads from palette[pen(0)]
    if (column == '0) begin
      base = ham6 ? widen4(pal_b_rdata) : pal_b_rdata;
    end else begin
      base = held_color;
    end

    if (ham6) begin
      unique case (s2_p[5:4])
        2'd0: held_color_next = widen4(pal_a_rdata);
        2'd1: held_color_next = (base & KEEP_RG) | COLOR_W'({s2_p[3:0], s2_p[3:0]});
        2'd2: held_color_next = (base & KEEP_GB) | {8'b0, s2_p[3:0], s2_p[3:0], 16'b0};
        2'd3: held_color_next = (base & KEEP_RB) | {16'b0, s2_p[3:0], s2_p[3:0], 8'b0};
      endcase
      rgb = held_color_next;
    end else if (ham8) begin
      unique case (s2_p[7:6])
        2'd0: held_color_next = pal_a_rdata;
        2'd1: held_color_next = (base & KEEP_RG8) | {24'b0, s2_p[5:0], 2'b0};
        2'd2: held_color_next = (base & KEEP_GB8) | {8'b0, s2_p[5:0], 18'b0};
        2'd3: held_color_next = (base & KEEP_RB8) | {16'b0, s2_p[5:0], 10'b0};
      endcase
      rgb = held_color_next;
    end else begin
      held_color_next = base;
      rgb             = pal_a_rdata;
    end

    // pixels left of the edge are decoded but dropped
    emit    = (column >= COL_W'(left_edge));
    is_last = (column >= last_col);
    if (emit && is_last) begin
      column_next = '0;
    end else begin
      column_next = column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_color <= '0;
      column     <= '0;
    end else if (en && s2_valid) begin
      held_color <= held_color_next;
      column     <= column_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s2_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= rgb;
      m_tlast <= is_last;
    end
  end

endmodule

// ===== design/chr_ram.sv =====
// chr_ram: generic single write, single read ram with registered read data
// read before write on the same address; no dependencies
module chr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== design/chr_checker.sv =====
// chr_checker: port-level checks for chunky_ham_to_rgb, bound to the top level
// depends on chr_pkg
module chr_checker
  import chr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [COLOR_W-1:0] m_tdata,
  input logic               m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // the input side is free whenever the output register can move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with room downstream");

  // the input side stalls only behind a stalled output word
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a downstream stall");

endmodule

bind chunky_ham_to_rgb chr_checker u_chr_checker (.*);

// ===== tb/tb_chunky_ham_to_rgb.sv =====
// tb_chunky_ham_to_rgb: self-checking testbench for the chunky pixel to rgb decoder
// covers clut, ham6 and ham8 decoding, pen remap, row framing and table loads
// depends on chr_pkg and chunky_ham_to_rgb
module tb_chunky_ham_to_rgb;
  import chr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CAP      = DEF_MAX_ROW_PIXELS;
  localparam int RANDOM_WORDS = 250;
  localparam int PEN_FILL     = 32;    // pen entries loaded; remapped pixels stay below
  localparam int PIPE_GAP     = 8;     // a little over the three stage pipeline
  localparam int DRAIN_LIMIT  = 4000;  // cycles to wait for late rgb words
  localparam int MAX_REPORTS  = 40;

  // kind and mode values that the block has no use for
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // hold-and-modify control field of a pixel
  localparam logic [1:0] HAM_LOAD  = 2'd0;
  localparam logic [1:0] HAM_BLUE  = 2'd1;
  localparam logic [1:0] HAM_RED   = 2'd2;
  localparam logic [1:0] HAM_GREEN = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PIXEL_W-1:0] pixel;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] rgb;
    logic               last;
  } rgb_word_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;  // pixel[7:0], table_index[15:8], table_value[47:16]
  logic [KIND_W-1:0]   s_tuser   = '0;  // kind[1:0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [COLOR_W-1:0]  m_tdata;         // rgb[31:0]
  logic                m_tlast;
  logic                cfg_we    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  chunky_ham_to_rgb #(.MAX_ROW_PIXELS(ROW_CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder model: tables, held colour, column and its own register copies
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] color_tab [TAB_D];
  logic [PIXEL_W-1:0] pen_map   [TAB_D];
  logic [COLOR_W-1:0] held_rgb  = '0;
  int                 row_col   = 0;
  logic [MODE_W-1:0]  cur_mode  = MODE_CLUT;
  logic               pen_on    = 1'b0;
  int                 left_e    = 0;
  int                 row_w     = 1;

  in_word_t  pending_words [$];  // stimulus waiting for the driver
  rgb_word_t rgb_due [$];        // decoded words not yet seen on m
  in_word_t  cur_word;
  rgb_word_t seen_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_queued = 0;
  int words_taken = 0;
  int rgb_checked = 0;
  int rows_closed = 0;
  int mismatches = 0;
  int phases = 0;

  // pen remap of a source pixel
  function automatic logic [PIXEL_W-1:0] pen_of(input logic [PIXEL_W-1:0] p);
    return pen_on ? pen_map[p] : p;
  endfunction

  // 4-bit components to 8-bit ones, upper byte cleared
  function automatic logic [COLOR_W-1:0] spread4(input logic [COLOR_W-1:0] v);
    return {8'h00, v[23:20], v[23:20], v[15:12], v[15:12], v[7:4], v[7:4]};
  endfunction

  // apply one accepted word to the model, queue the rgb word it emits
  function automatic void decode_word(input in_word_t w);
    int                 span;
    int                 end_col;
    logic [PIXEL_W-1:0] p;
    logic [3:0]         n4;
    logic [5:0]         n6;
    logic [COLOR_W-1:0] start;
    logic [COLOR_W-1:0] rgb;
    rgb_word_t          r;
    case (w.kind)
      KIND_PALETTE: color_tab[w.index] = w.value;
      KIND_PEN:     pen_map[w.index] = w.value[7:0];
      KIND_PIXEL: begin
        span = (row_w == 0) ? 1 : (row_w > ROW_CAP) ? ROW_CAP : row_w;
        end_col = left_e + span - 1;
        // row start reloads the held colour from the entry of pen 0
        if (row_col == 0) begin
          start = color_tab[pen_of('0)];
          held_rgb = (cur_mode == MODE_HAM6) ? spread4(start) : start;
        end
        p = pen_of(w.pixel);
        n4 = p[3:0];
        n6 = p[5:0];
        if (cur_mode == MODE_HAM6) begin
          case (p[5:4])
            HAM_LOAD:  held_rgb = spread4(color_tab[{4'h0, n4}]);
            HAM_BLUE:  held_rgb = (held_rgb & KEEP_RG) | {24'h0, n4, n4};
            HAM_RED:   held_rgb = (held_rgb & KEEP_GB) | {8'h0, n4, n4, 16'h0};
            HAM_GREEN: held_rgb = (held_rgb & KEEP_RB) | {16'h0, n4, n4, 8'h0};
          endcase
          rgb = held_rgb;
        end else if (cur_mode == MODE_HAM8) begin
          case (p[7:6])
            HAM_LOAD:  held_rgb = color_tab[{2'b00, n6}];
            HAM_BLUE:  held_rgb = (held_rgb & KEEP_RG8) | {24'h0, n6, 2'b00};
            HAM_RED:   held_rgb = (held_rgb & KEEP_GB8) | {8'h0, n6, 18'h0};
            HAM_GREEN: held_rgb = (held_rgb & KEEP_RB8) | {16'h0, n6, 10'h0};
          endcase
          rgb = held_rgb;
        end else begin
          rgb = color_tab[p];
        end
        // pixels left of the edge advance the column only
        if (row_col < left_e) begin
          row_col++;
        end else begin
          r.rgb = rgb;
          r.last = (row_col >= end_col);
          row_col = r.last ? 0 : row_col + 1;
          rgb_due.push_back(r);
        end
      end
      default: ;  // spare kind leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents pending words, updates the model on each accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_word(cur_word);
        words_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_word.value, cur_word.index, cur_word.pixel};
          s_tuser <= cur_word.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each rgb word with the oldest due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rgb_checked++;
        if (m_tlast) rows_closed++;
        if (rgb_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $error("unexpected rgb word %h", m_tdata);
        end else begin
          seen_word = rgb_due.pop_front();
          if (m_tdata !== seen_word.rgb) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $error("rgb: expected %h, got %h", seen_word.rgb, m_tdata);
          end
          if (m_tlast !== seen_word.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $error("row_last: expected %b, got %b", seen_word.last, m_tlast);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic [KIND_W-1:0] kind,
                                    input logic [PIXEL_W-1:0] pixel,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic [COLOR_W-1:0] value);
    in_word_t w;
    w.kind = kind;
    w.pixel = pixel;
    w.index = idx;
    w.value = value;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_pixel(input logic [PIXEL_W-1:0] pixel);
    push_word(KIND_PIXEL, pixel, INDEX_W'($urandom), $urandom);
  endfunction

  // mostly pixels, some table writes, a few spare kinds; returns 1 if it counts
  // with the pen table on, pixels stay within the loaded pen entries
  function automatic bit push_random_word(input bit pen);
    int                 r;
    logic [PIXEL_W-1:0] px;
    r = $urandom_range(0, 99);
    px = pen ? PIXEL_W'($urandom_range(0, PEN_FILL - 1)) : PIXEL_W'($urandom);
    if (r < 84) push_word(KIND_PIXEL, px, INDEX_W'($urandom), $urandom);
    else if (r < 91) push_word(KIND_PALETTE, px, INDEX_W'($urandom), $urandom);
    else if (r < 98) push_word(KIND_PEN, px, INDEX_W'($urandom), $urandom);
    else push_word(KIND_SPARE, px, INDEX_W'($urandom), $urandom);
    return (r < 98);
  endfunction

  task automatic set_idle(input idle_t k);
    case (k)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      IDLE_BOTH: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // one register write; the model takes the value along with the block
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      REG_COLOR_MODE:    cur_mode = val[MODE_W-1:0];
      REG_USE_PEN_TABLE: pen_on = val[0];
      REG_LEFT_EDGE:     left_e = val & 32'hfff;
      REG_ROW_WIDTH:     row_w = val & 32'h1fff;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [MODE_W-1:0] mode, input bit pen,
                          input int ledge, input int width);
    write_reg(REG_COLOR_MODE, int'(mode));
    write_reg(REG_USE_PEN_TABLE, int'(pen));
    write_reg(REG_LEFT_EDGE, ledge);
    write_reg(REG_ROW_WIDTH, width);
    phases++;
  endtask

  // wait for every word to be taken and every rgb word to arrive, then let
  // hidden pixels and table writes run out of the pipeline
  task automatic settle();
    int waited;
    while (words_taken != words_queued) @(posedge clk);
    waited = 0;
    while (rgb_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (rgb_due.size() != 0) begin
      $error("%0d rgb words never arrived", rgb_due.size());
      mismatches += rgb_due.size();
      rgb_due.delete();
    end
    repeat (PIPE_GAP) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int               n;
    int               counted;
    int               r;
    logic [MODE_W-1:0] mode;
    bit               pen;
    int               ledge;
    int               width;
    idle_t            k;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill the palette and the low pen entries; remapped pixels stay within them
    set_idle(IDLE_BOTH);
    for (int i = 0; i < TAB_D; i++)
      push_word(KIND_PALETTE, PIXEL_W'($urandom), INDEX_W'(i),
                (i == 0) ? 32'hffff_ffff : (i == TAB_D - 1) ? 32'h0 : $urandom);
    for (int i = 0; i < PEN_FILL; i++)
      push_word(KIND_PEN, PIXEL_W'($urandom), INDEX_W'(i), $urandom);
    settle();

    // directed: clut at reset values, every pixel closes a one pixel row
    set_idle(IDLE_NONE);
    push_pixel(8'h00);
    push_pixel(8'hff);
    push_word(KIND_SPARE, 8'hff, 8'hff, 32'hffff_ffff);
    push_pixel(8'h80);
    settle();

    // ham6 with a hidden first pixel: load, then blue, red and green modify
    set_regs(MODE_HAM6, 1'b0, 1, 4);
    push_pixel(8'h3c);
    push_pixel(8'h03);
    push_pixel(8'h1f);
    push_pixel(8'h2a);
    push_pixel(8'h35);
    settle();

    // ham8 through the pen table, oversize width saturates; tables change mid-row
    set_regs(MODE_HAM8, 1'b1, 0, 8191);
    push_pixel(8'h00);
    push_pixel(8'h1f);
    push_pixel(8'h07);
    push_pixel(8'h13);
    push_pixel(8'h1c);
    push_word(KIND_PALETTE, 8'h00, 8'h00, 32'h0);
    push_word(KIND_PEN, 8'h00, 8'h1f, 32'hffff_ff00);
    push_pixel(8'h1f);
    settle();

    // spare mode decodes as clut; narrowing the row mid-row ends it at once
    set_regs(MODE_SPARE, 1'b0, 0, 1);
    push_pixel(8'haa);
    push_pixel(8'h55);
    settle();

    // random phases: settings drawn with the width extremes and a zero left edge included, idling rotated
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      k = idle_t'(phases % 4);
      set_idle(k);
      mode = MODE_W'($urandom_range(0, 3));
      pen = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      ledge = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      r = $urandom_range(0, 9);
      width = (r == 0) ? 0 : (r == 1) ? 1 : (r < 8) ? $urandom_range(2, 12) :
              (r == 8) ? $urandom_range(13, 64) : $urandom_range(ROW_CAP, 8191);
      set_regs(mode, pen, ledge, width);
      n = $urandom_range(30, 80);
      repeat (n) counted += int'(push_random_word(pen));
      settle();
    end

    $display("run covered %0d words in %0d register settings", words_taken, phases);
    $display("checked %0d rgb words closing %0d rows", rgb_checked, rows_closed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
